// ===== rtl/core/fbpa_pkg.sv =====
`default_nettype none

package fbpa_pkg;

    // field widths fixed by the request/response format
    localparam int OP_W     = 1;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 9;
    localparam int COUNT_W  = 5;

    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic init_step;   // write one link entry of the startup sweep
        logic take;        // request transfer this cycle
        logic pop_finish;  // link read data is back, complete the pop
    } t_ctrl_cmd;

    typedef struct packed {
        logic init_last;   // sweep is at the last entry
        logic pop_req;     // pending request is an alloc on a non-empty list
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/core/fbpa_req_if.sv =====
`default_nettype none

interface fbpa_req_if import fbpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic               block_given;
    logic [INDEX_W-1:0] block_index;

    modport source (output valid, output op, output block_given, output block_index,
                    input ready);
    modport sink   (input valid, input op, input block_given, input block_index,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fbpa_rsp_if.sv =====
`default_nettype none

interface fbpa_rsp_if import fbpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  granted_index;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COUNT_W-1:0]  blocks_in_use;
    logic                pool_empty;

    modport source (output valid, output status, output granted_index, output byte_offset,
                    output blocks_in_use, output pool_empty, input ready);
    modport sink   (input valid, input status, input granted_index, input byte_offset,
                    input blocks_in_use, input pool_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fbpa_ram.sv =====
`default_nettype none

module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/fbpa_ctrl.sv =====
`default_nettype none

module fbpa_ctrl import fbpa_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_dp_stat  i_stat,
    output t_ctrl_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_ready;

    // outputs
    always_comb begin
        o_cmd    = '0;
        in_ready = 1'b0;
        case (r_state)
            ST_INIT: begin
                o_cmd.init_step = 1'b1;
            end
            ST_IDLE: begin
                // result register must be empty or draining this cycle
                in_ready   = !r_out_valid || i_out_ready;
                o_cmd.take = i_in_valid && in_ready;
            end
            ST_READ: begin
                o_cmd.pop_finish = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_stat.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_cmd.take && i_stat.pop_req) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if ((o_cmd.take && !i_stat.pop_req) || o_cmd.pop_finish) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

    // pop completion always finds the result register free
    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_READ |-> !r_out_valid)
        else $error("result register busy while a pop completes");

    a_pop_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take && i_stat.pop_req |=> r_state == ST_READ)
        else $error("pop transfer did not enter the link read");

    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_READ |=> r_out_valid)
        else $error("pop produced no result");

endmodule

`default_nettype wire

// ===== rtl/core/fbpa_datapath.sv =====
`default_nettype none

module fbpa_datapath import fbpa_pkg::*; #(
    parameter int BLOCK_COUNT = 16,
    parameter int BLOCK_BYTES = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_ctrl_cmd           i_cmd,
    output t_dp_stat                 o_stat,
    input  wire logic [OP_W-1:0]     i_op,
    input  wire logic                i_block_given,
    input  wire logic [INDEX_W-1:0]  i_block_index,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [INDEX_W-1:0]  o_granted_index,
    output logic      [OFFSET_W-1:0] o_byte_offset,
    output logic      [COUNT_W-1:0]  o_blocks_in_use,
    output logic                     o_pool_empty
);

    localparam int AW     = $clog2(BLOCK_COUNT);
    localparam int CNT_W  = $clog2(BLOCK_COUNT + 1);
    localparam int BB_W   = $clog2(BLOCK_BYTES + 1);
    localparam int PROD_W = AW + BB_W;
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    localparam logic [CNT_W-1:0] EMPTY_MARK = CNT_W'(BLOCK_COUNT);
    localparam logic [AW-1:0]    LAST_ADDR  = AW'(BLOCK_COUNT - 1);

    logic [CNT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_used, n_used;
    logic [AW-1:0]    r_init_cnt, n_init_cnt;
    logic [AW-1:0]    r_grant;

    logic [STATUS_W-1:0] r_status, n_status;
    logic [INDEX_W-1:0]  r_granted, n_granted;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [COUNT_W-1:0]  r_used_out, n_used_out;
    logic                r_empty, n_empty;
    logic                load_out;

    logic             is_alloc;
    logic             head_empty;
    logic             free_ok;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [CNT_W-1:0] wr_data;
    logic [CNT_W-1:0] rd_data;
    logic [PROD_W-1:0] prod;

    assign is_alloc   = (i_op == OP_ALLOC);
    assign head_empty = (r_head == EMPTY_MARK);
    assign free_ok    = i_block_given && (CMP_W'(i_block_index) < CMP_W'(BLOCK_COUNT));

    assign o_stat.init_last = (r_init_cnt == LAST_ADDR);
    assign o_stat.pop_req   = is_alloc && !head_empty;

    // link store: startup sweep writes i+1, a free writes the old head
    assign wr_en   = i_cmd.init_step || (i_cmd.take && !is_alloc && free_ok);
    assign wr_addr = i_cmd.init_step ? r_init_cnt : AW'(i_block_index);
    assign wr_data = i_cmd.init_step ? (CNT_W'(r_init_cnt) + CNT_W'(1)) : r_head;

    fbpa_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BLOCK_COUNT)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (AW'(r_head)),
        .o_rd_data (rd_data)
    );

    assign prod = PROD_W'(r_grant) * PROD_W'(BLOCK_BYTES);

    always_comb begin
        n_head     = r_head;
        n_used     = r_used;
        n_init_cnt = r_init_cnt;
        load_out   = 1'b0;
        n_status   = STATUS_DONE;
        n_granted  = '0;
        n_offset   = '0;
        n_used_out = COUNT_W'(r_used);
        n_empty    = head_empty;

        if (i_cmd.init_step) begin
            n_init_cnt = r_init_cnt + AW'(1);
        end

        if (i_cmd.take) begin
            if (is_alloc) begin
                if (head_empty) begin
                    load_out = 1'b1;
                    n_status = STATUS_EMPTY;
                end else if (r_used < EMPTY_MARK) begin
                    n_used = r_used + CNT_W'(1);
                end
            end else if (free_ok) begin
                n_head     = CNT_W'(i_block_index);
                load_out   = 1'b1;
                n_empty    = 1'b0;
                if (r_used != '0) begin
                    n_used = r_used - CNT_W'(1);
                end
                n_used_out = COUNT_W'(n_used);
            end else begin
                load_out = 1'b1;
                n_status = STATUS_IGNORED;
            end
        end

        if (i_cmd.pop_finish) begin
            n_head     = rd_data;
            load_out   = 1'b1;
            n_granted  = INDEX_W'(r_grant);
            n_offset   = OFFSET_W'(prod);
            n_empty    = (rd_data == EMPTY_MARK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_used     <= '0;
            r_init_cnt <= '0;
        end else begin
            r_head     <= n_head;
            r_used     <= n_used;
            r_init_cnt <= n_init_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && o_stat.pop_req) begin
            r_grant <= AW'(r_head);
        end
        if (load_out) begin
            r_status   <= n_status;
            r_granted  <= n_granted;
            r_offset   <= n_offset;
            r_used_out <= n_used_out;
            r_empty    <= n_empty;
        end
    end

    assign o_status        = r_status;
    assign o_granted_index = r_granted;
    assign o_byte_offset   = r_offset;
    assign o_blocks_in_use = r_used_out;
    assign o_pool_empty    = r_empty;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= EMPTY_MARK)
        else $error("block count beyond pool size");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= EMPTY_MARK)
        else $error("free list head out of range");

endmodule

`default_nettype wire

// ===== rtl/core/fixed_block_pool_allocator.sv =====
// Fixed-size block pool allocator, LIFO free list.
//
// i_req (sink): one request per transfer. op selects alloc or free;
// block_given and block_index name the block on a free.
// o_rsp (source): one response per request, in request order: status,
// granted index, byte offset, blocks in use and the empty flag.
//
// A free, a null free or an alloc on an empty pool shows its response in
// the cycle after the request transfer; an alloc that pops a block also
// passes through ST_READ, set by the registered read of the link memory.
// One free per cycle unless the receiver stalls; i_req.ready is low in ST_READ.
//
// After reset the link memory is swept, one entry per cycle, over all
// BLOCK_COUNT entries; i_req.ready stays low during the sweep.
// One response is held in an output register. While the receiver stalls,
// the block holds that response and lowers i_req.ready until it is taken.
`default_nettype none

module fixed_block_pool_allocator import fbpa_pkg::*; #(
    parameter int BLOCK_COUNT = 16,
    parameter int BLOCK_BYTES = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fbpa_req_if.sink    i_req,
    fbpa_rsp_if.source  o_rsp
);

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fbpa_datapath #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (i_req.op),
        .i_block_given   (i_req.block_given),
        .i_block_index   (i_req.block_index),
        .o_status        (o_rsp.status),
        .o_granted_index (o_rsp.granted_index),
        .o_byte_offset   (o_rsp.byte_offset),
        .o_blocks_in_use (o_rsp.blocks_in_use),
        .o_pool_empty    (o_rsp.pool_empty)
    );

endmodule

`default_nettype wire
